@@ rtl/core/ps2md_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet decoder.
`timescale 1ns / 1ps
package ps2md_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] RESET_MARK    = 8'hAA;
  localparam logic [7:0] OVERFLOW_MASK = 8'h80 | 8'h40;
  localparam logic [7:0] ID_EXT3       = 8'd3;
  localparam logic [7:0] ID_EXT4       = 8'd4;

  localparam logic [3:0] SCROLL_UP     = 4'h1;
  localparam logic [3:0] SCROLL_DOWN   = 4'hF;
  localparam logic [3:0] SCROLL_RIGHT  = 4'h2;
  localparam logic [3:0] SCROLL_LEFT   = 4'hE;

  localparam logic [1:0] KIND_MOVE     = 2'd0;
  localparam logic [1:0] KIND_BUTTON   = 2'd1;
  localparam logic [1:0] KIND_SCROLL   = 2'd2;
  localparam logic [1:0] KIND_RESET    = 2'd3;

  // Event mask bit positions, in emission order.
  localparam int NUM_EV = 8;
  localparam logic [2:0] EV_MOVE   = 3'd0;
  localparam logic [2:0] EV_SCROLL = 3'd6;
  localparam logic [2:0] EV_RESET  = 3'd7;

  // One queued packet (or reset mark) with the events it still has to emit.
  typedef struct packed {
    logic [NUM_EV-1:0] ev;
    logic signed [8:0] mx;
    logic signed [8:0] my;
    logic [4:0]        btn_new;
    logic signed [1:0] sx;
    logic signed [1:0] sy;
  } job_t;

endpackage

@@ rtl/core/ps2md_front.sv @@
// Front end: byte intake, packet assembly, button tracking and event classification.
`timescale 1ns / 1ps
module ps2md_front import ps2md_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] mouse_id,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] data_byte,
  input  logic       q_full,
  output logic       push,
  output job_t       job
);

  logic [2:0] byte_count;
  logic [7:0] held [3];
  logic [4:0] button_state;

  logic       accept;
  logic       ext;
  logic       complete;
  logic [7:0] b0, b1, b2, b3;
  logic [4:0] btn_new;
  logic [4:0] chg;
  logic       overflow;
  logic       scroll_ok;
  logic       is_mark;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign ext      = (mouse_id == ID_EXT3) || (mouse_id == ID_EXT4);
  assign complete = ext ? (byte_count >= 3'd3) : (byte_count >= 3'd2);
  assign is_mark  = (data_byte == RESET_MARK);

  // Packet bytes: held bytes first, then the incoming byte, zero beyond.
  always_comb begin
    b0 = (byte_count > 3'd0) ? held[0] : data_byte;
    b1 = (byte_count > 3'd1) ? held[1] : ((byte_count == 3'd1) ? data_byte : 8'h00);
    b2 = (byte_count > 3'd2) ? held[2] : ((byte_count == 3'd2) ? data_byte : 8'h00);
    b3 = (byte_count == 3'd3) ? data_byte : 8'h00;
  end

  always_comb begin
    overflow  = (b0 & OVERFLOW_MASK) != 8'h00;
    btn_new   = {(ext ? b3[5:4] : button_state[4:3]), b0[2:0]};
    chg       = btn_new ^ button_state;
    scroll_ok = 1'b0;
    job       = '0;
    job.sx    = 2'sd0;
    job.sy    = 2'sd0;
    if (mouse_id == ID_EXT4) begin
      case (b3[3:0])
        SCROLL_UP:    begin scroll_ok = 1'b1; job.sy = -2'sd1; end
        SCROLL_DOWN:  begin scroll_ok = 1'b1; job.sy = 2'sd1;  end
        SCROLL_RIGHT: begin scroll_ok = 1'b1; job.sx = 2'sd1;  end
        SCROLL_LEFT:  begin scroll_ok = 1'b1; job.sx = -2'sd1; end
        default:      scroll_ok = 1'b0;
      endcase
    end
    job.mx      = {b0[4], b1};
    job.my      = {b0[5], b2};
    job.btn_new = btn_new;
    job.ev      = {1'b0, scroll_ok, chg, ((b1 | b2) != 8'h00)};
    push        = 1'b0;
    if (!mode && is_mark) begin
      job      = '0;
      job.ev   = NUM_EV'(1) << EV_RESET;
      push     = accept;
    end else if (!mode && complete && !overflow) begin
      push = accept && (job.ev != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= 3'd0;
      button_state <= 5'd0;
    end else if (accept) begin
      if (mode) begin
        byte_count <= 3'd0;
      end else if (is_mark) begin
        byte_count   <= 3'd0;
        button_state <= 5'd0;
      end else if (!complete) begin
        byte_count <= byte_count + 3'd1;
      end else begin
        byte_count <= 3'd0;
        if (!overflow) begin
          button_state <= btn_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !mode && !is_mark && !complete) begin
      held[byte_count[1:0]] <= data_byte;
    end
  end

`ifndef SYNTHESIS
  a_mark_clears_buttons: assert property (@(posedge clk) disable iff (rst)
    (accept && !mode && is_mark) |=> (button_state == 5'd0 && byte_count == 3'd0))
    else $error("reset mark did not clear button state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= 3'd3)
    else $error("byte count out of range");
`endif

endmodule

@@ rtl/core/ps2md_fifo.sv @@
// Short job queue between the front end and the event sequencer.
`timescale 1ns / 1ps
module ps2md_fifo import ps2md_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");
`endif

endmodule

@@ rtl/core/ps2md_back.sv @@
// Back end: walks a job's event mask and drives the registered output word.
`timescale 1ns / 1ps
module ps2md_back import ps2md_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  job_t              head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic signed [8:0] move_x,
  output logic signed [8:0] move_y,
  output logic [2:0]        button_index,
  output logic              button_pressed,
  output logic signed [1:0] scroll_x,
  output logic signed [1:0] scroll_y,
  output logic              last
);

  job_t              cur;
  logic [NUM_EV-1:0] pending;

  logic              busy;
  logic              out_free;
  logic              emit;
  logic [NUM_EV-1:0] src;
  logic [NUM_EV-1:0] rest;
  job_t              sjob;
  logic [2:0]        idx;
  logic [2:0]        bidx;

  function automatic logic [2:0] first_set(input logic [NUM_EV-1:0] m);
    logic [2:0] r;
    r = '0;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    return r;
  endfunction

  always_comb begin
    busy     = (pending != '0);
    out_free = !out_valid || !out_stall;
    src      = busy ? pending : head.ev;
    sjob     = busy ? cur : head;
    emit     = out_free && (busy || !q_empty);
    pop      = out_free && !busy && !q_empty;
    idx      = first_set(src);
    rest     = src & ~(NUM_EV'(1) << idx);
    bidx     = idx - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      pending   <= rest;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (emit) begin
      move_x         <= 9'sd0;
      move_y         <= 9'sd0;
      button_index   <= 3'd0;
      button_pressed <= 1'b0;
      scroll_x       <= 2'sd0;
      scroll_y       <= 2'sd0;
      last           <= (rest == '0);
      case (idx)
        EV_MOVE: begin
          kind   <= KIND_MOVE;
          move_x <= sjob.mx;
          move_y <= sjob.my;
        end
        EV_SCROLL: begin
          kind     <= KIND_SCROLL;
          scroll_x <= sjob.sx;
          scroll_y <= sjob.sy;
        end
        EV_RESET: begin
          kind <= KIND_RESET;
        end
        default: begin
          kind           <= KIND_BUTTON;
          button_index   <= bidx;
          button_pressed <= sjob.btn_new[bidx];
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pending_shown: assert property (@(posedge clk) disable iff (rst)
    (pending != '0) |-> out_valid)
    else $error("events pending with no word on the output");

  a_reset_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_RESET) |-> (last && pending == '0))
    else $error("device reset event not emitted alone");
`endif

endmodule

@@ rtl/core/ps2_mouse_packet_decoder.sv @@
// Top level of the PS/2 mouse packet decoder: register port and block wiring.
//
// Input channel (in_valid/in_stall, mode, data_byte): one word per received
// mouse byte, or a resynchronize request when mode is 1. A word is taken at a
// clock edge with in_valid high and in_stall low; in_stall rises only while
// the job queue (QUEUE_DEPTH entries) is full, else bytes go in one per cycle.
// Output channel (out_valid/out_stall and event fields): one word per event.
// A byte completing a packet that has events and no overflow bit, or a 0xAA
// reset mark, queues a job at the edge it is taken; its events load into the
// output register one per cycle while it is free, up to seven per packet, last
// set on the final. The output register holds while out_stall is high; the
// front end keeps taking bytes until the queue fills behind it.
// mouse_id is written over the APB port at byte address 0 (reset 0) and
// must only change while the block is idle.
// Reset (rst, synchronous) clears the byte count, buttons, queue and output;
// no clearing pass is needed.
`timescale 1ns / 1ps
module ps2_mouse_packet_decoder import ps2md_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic signed [8:0] move_x,
  output logic signed [8:0] move_y,
  output logic [2:0]        button_index,
  output logic              button_pressed,
  output logic signed [1:0] scroll_x,
  output logic signed [1:0] scroll_y,
  output logic              last
);

  logic [7:0] mouse_id;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  job_t       job;
  job_t       head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, mouse_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_id <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      mouse_id <= pwdata[7:0];
    end
  end

  ps2md_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mouse_id  (mouse_id),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .job       (job)
  );

  ps2md_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  ps2md_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .move_x         (move_x),
    .move_y         (move_y),
    .button_index   (button_index),
    .button_pressed (button_pressed),
    .scroll_x       (scroll_x),
    .scroll_y       (scroll_y),
    .last           (last)
  );

endmodule

@@ tb/ps2_event_checker.sv @@
// Event checker for the PS/2 mouse packet decoder: predicts events and compares them.
`timescale 1ns / 1ps
module ps2_event_checker import ps2md_pkg::*; #(
  parameter logic [2:0] MOUSE_ID_ADDR = 3'd0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              mode,
  input  logic [7:0]        data_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        kind,
  input  logic signed [8:0] move_x,
  input  logic signed [8:0] move_y,
  input  logic [2:0]        button_index,
  input  logic              button_pressed,
  input  logic signed [1:0] scroll_x,
  input  logic signed [1:0] scroll_y,
  input  logic              last,
  output int                fail_count,
  output int                pending,
  output int                events_checked
);

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [8:0] mx;
    logic signed [8:0] my;
    logic [2:0]        bidx;
    logic              bpress;
    logic signed [1:0] sx;
    logic signed [1:0] sy;
    logic              last;
  } mouse_event_t;

  logic [7:0]   mouse_id;
  logic [1:0]   byte_count;
  logic [7:0]   held_bytes [3];
  logic [4:0]   buttons;
  mouse_event_t expected_events [$];
  int           n_fail;
  int           n_checked;

  function automatic mouse_event_t make_event(input logic [1:0] k, input logic [8:0] mx,
                                              input logic [8:0] my, input logic [2:0] bidx,
                                              input logic bpress, input logic [1:0] sx,
                                              input logic [1:0] sy);
    mouse_event_t ev;
    ev = '{kind: k, mx: mx, my: my, bidx: bidx, bpress: bpress, sx: sx, sy: sy, last: 1'b0};
    return ev;
  endfunction

  // Update the packet state with one word and queue the events it causes.
  task automatic decode_mouse_byte(input logic m, input logic [7:0] c);
    mouse_event_t evs [$];
    mouse_event_t ev;
    logic [7:0]   b [4];
    logic         ext;
    logic         now;
    int           plen;
    ext  = (mouse_id == ID_EXT3) || (mouse_id == ID_EXT4);
    plen = ext ? 4 : 3;
    if (m) begin
      byte_count = 2'd0;
      return;
    end
    if (c == RESET_MARK) begin
      byte_count = 2'd0;
      buttons    = 5'd0;
      ev = make_event(KIND_RESET, 9'd0, 9'd0, 3'd0, 1'b0, 2'd0, 2'd0);
      ev.last = 1'b1;
      expected_events.push_back(ev);
      return;
    end
    if (int'(byte_count) + 1 < plen) begin
      held_bytes[byte_count] = c;
      byte_count = byte_count + 2'd1;
      return;
    end
    // Held bytes first, then the incoming one; a shortened packet drops it.
    for (int i = 0; i < 4; i++) begin
      if (i < int'(byte_count) && i < 3) b[i] = held_bytes[i];
      else if (i == int'(byte_count))    b[i] = c;
      else                               b[i] = 8'h00;
    end
    byte_count = 2'd0;
    if ((b[0] & OVERFLOW_MASK) != 8'h00) return;
    if (b[1] != 8'h00 || b[2] != 8'h00)
      evs.push_back(make_event(KIND_MOVE, {b[0][4], b[1]}, {b[0][5], b[2]},
                               3'd0, 1'b0, 2'd0, 2'd0));
    for (int i = 0; i < 3; i++) begin
      now = b[0][i];
      if (now != buttons[i]) begin
        buttons[i] = now;
        evs.push_back(make_event(KIND_BUTTON, 9'd0, 9'd0, 3'(i), now, 2'd0, 2'd0));
      end
    end
    if (ext) begin
      for (int i = 0; i < 2; i++) begin
        now = b[3][i + 4];
        if (now != buttons[i + 3]) begin
          buttons[i + 3] = now;
          evs.push_back(make_event(KIND_BUTTON, 9'd0, 9'd0, 3'(i + 3), now, 2'd0, 2'd0));
        end
      end
    end
    if (mouse_id == ID_EXT4) begin
      case (b[3][3:0])
        SCROLL_UP:    evs.push_back(make_event(KIND_SCROLL, 9'd0, 9'd0, 3'd0, 1'b0,
                                               2'b00, 2'b11));
        SCROLL_DOWN:  evs.push_back(make_event(KIND_SCROLL, 9'd0, 9'd0, 3'd0, 1'b0,
                                               2'b00, 2'b01));
        SCROLL_RIGHT: evs.push_back(make_event(KIND_SCROLL, 9'd0, 9'd0, 3'd0, 1'b0,
                                               2'b01, 2'b00));
        SCROLL_LEFT:  evs.push_back(make_event(KIND_SCROLL, 9'd0, 9'd0, 3'd0, 1'b0,
                                               2'b11, 2'b00));
        default: ;
      endcase
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endtask

  always @(posedge clk) begin
    mouse_event_t got;
    mouse_event_t want;
    if (rst) begin
      mouse_id   = 8'd0;
      byte_count = 2'd0;
      buttons    = 5'd0;
      expected_events.delete();
      n_fail     = 0;
      n_checked  = 0;
    end else begin
      if (psel && penable && pready && paddr == MOUSE_ID_ADDR) begin
        if (pwrite) begin
          mouse_id = pwdata[7:0];
        end else if (prdata != {24'h0, mouse_id}) begin
          if (n_fail < 10)
            $display("%0t: mouse_id readback expected %0d, got %0d", $time, mouse_id, prdata);
          n_fail++;
        end
      end
      if (in_valid && !in_stall) decode_mouse_byte(mode, data_byte);
      if (out_valid && !out_stall) begin
        got = {kind, move_x, move_y, button_index, button_pressed, scroll_x, scroll_y, last};
        n_checked++;
        if (expected_events.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: unexpected event kind=%0d x=%0d y=%0d btn=%0d/%0d scroll=%0d,%0d last=%0d",
                     $time, got.kind, got.mx, got.my, got.bidx, got.bpress, got.sx, got.sy,
                     got.last);
          n_fail++;
        end else begin
          want = expected_events.pop_front();
          if (got.kind != want.kind || got.mx != want.mx || got.my != want.my ||
              got.bidx != want.bidx || got.bpress != want.bpress || got.sx != want.sx ||
              got.sy != want.sy || got.last != want.last) begin
            if (n_fail < 10) begin
              $display("%0t: event mismatch", $time);
              $display("  expected kind=%0d x=%0d y=%0d btn=%0d/%0d scroll=%0d,%0d last=%0d",
                       want.kind, want.mx, want.my, want.bidx, want.bpress, want.sx, want.sy,
                       want.last);
              $display("  got      kind=%0d x=%0d y=%0d btn=%0d/%0d scroll=%0d,%0d last=%0d",
                       got.kind, got.mx, got.my, got.bidx, got.bpress, got.sx, got.sy,
                       got.last);
            end
            n_fail++;
          end
        end
      end
    end
    fail_count     <= n_fail;
    pending        <= expected_events.size();
    events_checked <= n_checked;
  end

endmodule

@@ tb/tb_ps2_mouse_packet_decoder.sv @@
// Testbench top for the PS/2 mouse packet decoder: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_ps2_mouse_packet_decoder;
  import ps2md_pkg::*;

  localparam logic [2:0] MOUSE_ID_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR    = 3'd4;  // index 1: no register there
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_WORDS   = 36;
  localparam int END_LIMIT     = 20000;
  // Mouse ID per random phase, phase 0 in the low byte.
  localparam logic [8:0][7:0] PHASE_IDS = {8'd2, 8'd1, ID_EXT4, ID_EXT3, 8'd255,
                                           ID_EXT4, 8'd0, ID_EXT4, ID_EXT3};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic              mode;
  logic [7:0]        data_byte;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        kind;
  logic signed [8:0] move_x;
  logic signed [8:0] move_y;
  logic [2:0]        button_index;
  logic              button_pressed;
  logic signed [1:0] scroll_x;
  logic signed [1:0] scroll_y;
  logic              last;
  int                fail_count;
  int                pending;
  int                events_checked;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_requests;
  int                words_sent;

  ps2_mouse_packet_decoder u_dut (.*);

  ps2_event_checker #(.MOUSE_ID_ADDR(MOUSE_ID_ADDR)) u_checker (.*);

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: random stalls, or a long hold-off when one is requested.
  initial begin
    int served;
    served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic m, input logic [7:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] b3, input bit four);
    send_word(1'b0, b0);
    send_word(1'b0, b1);
    send_word(1'b0, b2);
    if (four) send_word(1'b0, b3);
  endtask

  // Hold the input until every expected event is out, then let the block settle.
  task automatic drain_events;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mouse_id(input logic [7:0] id);
    drain_events();
    apb_access(1'b1, MOUSE_ID_ADDR, {24'h0, id});
    apb_access(1'b0, MOUSE_ID_ADDR, 32'h0);
  endtask

  task automatic send_random_packet(input bit four);
    logic [31:0] r;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    r  = $urandom;
    b0 = r[7:0];
    b1 = r[15:8];
    b2 = r[23:16];
    b3 = r[31:24];
    // Keep most packets free of overflow so they reach the decode.
    if ($urandom_range(0, 9) != 0) b0 = b0 & ~OVERFLOW_MASK;
    if ($urandom_range(0, 3) == 0) b1 = 8'h00;
    if ($urandom_range(0, 3) == 0) b2 = 8'h00;
    case ($urandom_range(0, 4))
      0: b3[3:0] = SCROLL_UP;
      1: b3[3:0] = SCROLL_DOWN;
      2: b3[3:0] = SCROLL_RIGHT;
      3: b3[3:0] = SCROLL_LEFT;
      default: ;
    endcase
    send_packet(b0, b1, b2, b3, four);
  endtask

  task automatic send_noise;
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: send_word(1'b1, r[7:0]);
      1: send_word(1'b0, RESET_MARK);
      2: send_word(1'b0, r[7:0]);
      default: begin
        // broken packet: a header, then resynchronize
        send_word(1'b0, r[7:0] & ~OVERFLOW_MASK);
        send_word(1'b1, r[15:8]);
      end
    endcase
  endtask

  task automatic run_phase(input logic [7:0] id, input int sidle, input int ridle,
                           input bit squeeze);
    int start;
    bit four;
    set_mouse_id(id);
    send_idle_pct = sidle;
    recv_idle_pct <= ridle;
    four  = (id == ID_EXT3) || (id == ID_EXT4);
    start = words_sent;
    if (squeeze) begin
      hold_requests <= hold_requests + 1;
      repeat (6) send_random_packet(four);
    end
    while (words_sent - start < PHASE_WORDS) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      else send_random_packet(four);
    end
  endtask

  initial begin
    int waited;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= 3'd0;
    pwdata        <= 32'h0;
    in_valid      <= 1'b0;
    mode          <= 1'b0;
    data_byte     <= 8'h00;
    hold_requests <= 0;
    recv_idle_pct <= 56;
    send_idle_pct = 15;
    words_sent    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Three-byte packets with the reset ID.
    send_word(1'b0, RESET_MARK);
    send_packet(8'h3F, 8'h00, 8'h01, 8'h00, 1'b0);
    send_packet(8'h08, 8'hFF, 8'hFF, 8'h00, 1'b0);
    send_packet(8'hC7, 8'h12, 8'h34, 8'h00, 1'b0);
    send_word(1'b0, 8'h09);
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'h08);
    send_word(1'b0, RESET_MARK);

    // Wheel and extra buttons; the spare address must leave mouse_id alone.
    set_mouse_id(ID_EXT4);
    apb_access(1'b1, SPARE_ADDR, 32'hFFFF_FF00);
    apb_access(1'b0, MOUSE_ID_ADDR, 32'h0);
    send_packet(8'h0F, 8'h01, 8'h02, 8'h31, 1'b1);
    send_packet(8'h08, 8'h00, 8'h00, 8'h0F, 1'b1);

    // Drop to three-byte packets with three bytes held: the next byte is discarded.
    set_mouse_id(ID_EXT3);
    send_word(1'b0, 8'h08);
    send_word(1'b0, 8'h01);
    send_word(1'b0, 8'h02);
    set_mouse_id(8'd0);
    send_word(1'b0, 8'h55);

    for (int p = 0; p < 9; p++) begin
      if (p < 3)      run_phase(PHASE_IDS[p], 15, 56, p == 1);
      else if (p < 6) run_phase(PHASE_IDS[p], 56, 15, 1'b0);
      else            run_phase(PHASE_IDS[p], 0, 0, p == 6);
    end

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < END_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words over mouse IDs 0, 1, 2, 3, 4 and 255; checked %0d events,",
             words_sent, events_checked);
    $display("with stalls on both sides and long output hold-offs; %0d failures.",
             fail_count + pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ ps2_mouse_packet_decoder.f @@
rtl/core/ps2md_pkg.sv
rtl/core/ps2md_front.sv
rtl/core/ps2md_fifo.sv
rtl/core/ps2md_back.sv
rtl/core/ps2_mouse_packet_decoder.sv
tb/ps2_event_checker.sv
tb/tb_ps2_mouse_packet_decoder.sv
